// ----- rtl/bcr_pkg.sv -----
// Shared constants for the body collision response block.
// No dependencies; imported by the top level.
`default_nettype none
package bcr_pkg;
  localparam int VEL_BITS_DEF    = 16;
  localparam int MASS_BITS_DEF   = 16;
  localparam int EFF_BITS        = 16;
  localparam int EFF_FRAC        = 15;
  localparam logic [EFF_BITS-1:0] EFF_RESET = 16'h8000;
  localparam int ENERGY_BITS     = 48;
  localparam int ENERGY_DIV      = 2000;
  localparam int ENERGY_HALF     = ENERGY_DIV / 2;
  // 2000 = 16 * 125: shift out the power of two, divide the rest by 125
  localparam int ENERGY_PRE_SHIFT   = 4;
  localparam int ENERGY_ODD         = ENERGY_DIV >> ENERGY_PRE_SHIFT;
  localparam int ENERGY_RECIP_SHIFT = 22;
  localparam int ENERGY_RECIP       =
    ((1 << ENERGY_RECIP_SHIFT) + ENERGY_ODD - 1) / ENERGY_ODD;
  localparam int ENERGY_LAT      = 4;
endpackage
`default_nettype wire

// ----- rtl/bcr_delay.sv -----
// Enabled shift line of N registers, cleared by reset.
// No dependencies.
`default_nettype none
module bcr_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);
  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) sh_r[i] <= '0;
    end else if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < N; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign dout = sh_r[N-1];
endmodule
`default_nettype wire

// ----- rtl/bcr_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, round half away
// from zero, saturate to OW signed bits. No dependencies.
`default_nettype none
module bcr_div #(
  parameter int NW = 36,
  parameter int DW = 32,
  parameter int OW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [NW-1:0] num,
  input  wire logic        [DW-1:0] den,
  output logic signed      [OW-1:0] quo
);
  localparam int QB = OW;
  localparam int XW = (NW > QB) ? NW : QB + 1;
  localparam int HW = XW - QB;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam logic [QB:0]   POS_LIM = {2'b00, {(OW-1){1'b1}}};
  localparam logic [QB:0]   NEG_LIM = {2'b01, {(OW-1){1'b0}}};
  localparam logic [OW-1:0] MAX_V   = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] MIN_V   = {1'b1, {(OW-1){1'b0}}};

  logic signed [XW-1:0] nx;
  logic [XW-1:0] mag;
  logic [HW-1:0] hi;
  logic ovf0;

  logic [DW-1:0] rem_r [QB+1];
  logic [QB-1:0] lo_r  [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic [DW-1:0] den_r [QB+1];
  logic          neg_r [QB+1];
  logic          ovf_r [QB+1];

  logic [DW-1:0] rem_nxt [QB+1];
  logic [QB-1:0] lo_nxt  [QB+1];
  logic [QB-1:0] q_nxt   [QB+1];

  logic          rnd;
  logic [QB:0]   qr;
  logic [QB:0]   negq;
  logic [OW-1:0] res;

  assign nx   = XW'(num);
  assign mag  = nx[XW-1] ? XW'(-nx) : XW'(nx);
  assign hi   = mag[XW-1:QB];
  assign ovf0 = CW'(hi) >= CW'(den);

  // one compare-subtract per stage
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    trial = '0;
    ge    = 1'b0;
    rem_nxt[0] = '0;
    lo_nxt[0]  = '0;
    q_nxt[0]   = '0;
    for (int k = 1; k <= QB; k++) begin
      trial      = {rem_r[k-1], lo_r[k-1][QB-1]};
      ge         = trial >= {1'b0, den_r[k-1]};
      rem_nxt[k] = ge ? DW'(trial - {1'b0, den_r[k-1]}) : trial[DW-1:0];
      lo_nxt[k]  = {lo_r[k-1][QB-2:0], 1'b0};
      q_nxt[k]   = {q_r[k-1][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(hi);
      lo_r[0]  <= mag[QB-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      neg_r[0] <= nx[XW-1];
      ovf_r[0] <= ovf0;
      for (int k = 1; k <= QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        q_r[k]   <= q_nxt[k];
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign rnd  = rem_r[QB] >= (den_r[QB] - rem_r[QB]);
  assign qr   = {1'b0, q_r[QB]} + (QB+1)'(rnd);
  assign negq = -qr;

  always_comb begin
    if (ovf_r[QB] || (neg_r[QB] ? (qr > NEG_LIM) : (qr > POS_LIM))) begin
      res = neg_r[QB] ? MIN_V : MAX_V;
    end else begin
      res = neg_r[QB] ? negq[OW-1:0] : qr[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) quo <= $signed(res);
  end
endmodule
`default_nettype wire

// ----- rtl/bcr_energy.sv -----
// Four-stage kinetic energy sum m1*|v1|^2 + m2*|v2|^2 of a body pair.
// No dependencies.
`default_nettype none
module bcr_energy #(
  parameter int VW = 16,
  parameter int MW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic        [MW-1:0] m1,
  input  wire logic        [MW-1:0] m2,
  input  wire logic signed [VW-1:0] v1x,
  input  wire logic signed [VW-1:0] v1y,
  input  wire logic signed [VW-1:0] v2x,
  input  wire logic signed [VW-1:0] v2y,
  output logic      [MW+2*VW+1:0]   energy
);
  logic signed [2*VW-1:0] p1x, p1y, p2x, p2y;
  logic [2*VW-1:0] s1x_r, s1y_r, s2x_r, s2y_r;
  logic [MW-1:0]   m1_r, m2_r, m1_r2, m2_r2;
  logic [2*VW:0]   ss1_r, ss2_r;
  logic [MW+2*VW:0] pm1_r, pm2_r;

  assign p1x = v1x * v1x;
  assign p1y = v1y * v1y;
  assign p2x = v2x * v2x;
  assign p2y = v2y * v2y;

  always_ff @(posedge clk) begin
    if (en) begin
      s1x_r  <= p1x;
      s1y_r  <= p1y;
      s2x_r  <= p2x;
      s2y_r  <= p2y;
      m1_r   <= m1;
      m2_r   <= m2;
      ss1_r  <= {1'b0, s1x_r} + {1'b0, s1y_r};
      ss2_r  <= {1'b0, s2x_r} + {1'b0, s2y_r};
      m1_r2  <= m1_r;
      m2_r2  <= m2_r;
      pm1_r  <= (MW+2*VW+1)'(m1_r2) * (MW+2*VW+1)'(ss1_r);
      pm2_r  <= (MW+2*VW+1)'(m2_r2) * (MW+2*VW+1)'(ss2_r);
      energy <= {1'b0, pm1_r} + {1'b0, pm2_r};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/body_collision_response_top.sv -----
// Top level of the body collision response pipeline.
// Depends on bcr_pkg, bcr_delay, bcr_div and bcr_energy.
`default_nettype none
// Collision response for a pair of 2D bodies, one transaction per clock.
// A transaction carries two masses, two Q8.8 velocity vectors and the kind
// (in_tuser: 0 elastic, 1 perfectly inelastic). Elastic mode applies the 1D
// elastic formula per axis and scales it by the Q1.15 efficiency register;
// inelastic mode gives both bodies the momentum-weighted common velocity.
// The result holds the four saturated velocities and the released kinetic
// energy over 1000 in signed Q.16. The pipeline takes a new transaction every
// cycle and holds as a whole while the output is stalled. Most of the
// pipeline depth lies in the bit-per-stage velocity dividers. The energy
// divide by 2000 adds a rounding offset, drops the factor of 16 and runs a
// byte-per-stage long division by 125 with a reciprocal multiply (six stages
// at default widths, plus an entry and an exit register). Both masses zero
// gives an all-zero result. Write the efficiency register only while the
// pipeline is empty.
module body_collision_response_top #(
  parameter int VELOCITY_BITS = bcr_pkg::VEL_BITS_DEF,
  parameter int MASS_BITS     = bcr_pkg::MASS_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // config: efficiency, Q1.15
  input  wire logic                          cfg_wr_en,
  input  wire logic [bcr_pkg::EFF_BITS-1:0]  cfg_wr_data,
  // in_tdata, low bit up: first_mass, second_mass, first_vel_x,
  // first_vel_y, second_vel_x, second_vel_y, zero pad to bytes
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [((2*MASS_BITS+4*VELOCITY_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: mode
  input  wire logic                          in_tuser,
  // out_tdata, low bit up: new_first_vel_x, new_first_vel_y,
  // new_second_vel_x, new_second_vel_y, released_energy, zero pad to bytes
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [((4*VELOCITY_BITS+bcr_pkg::ENERGY_BITS+7)/8)*8-1:0] out_tdata
);
  import bcr_pkg::*;

  localparam int V      = VELOCITY_BITS;
  localparam int M      = MASS_BITS;
  localparam int OUT_W  = ((4*V+ENERGY_BITS+7)/8)*8;
  localparam int PW     = V + M + 2;             // product width
  localparam int TW     = PW + 1;                // combined term width
  localparam int NW     = TW + EFF_BITS + 1;     // divider numerator width
  localparam int DW     = M + 1 + EFF_FRAC;      // divider denominator width
  localparam int DL     = V + 2;                 // velocity divider latency
  localparam int EW     = M + 2*V + 2;           // energy width
  localparam int EYW    = EW + 1;                // energy magnitude plus offset
  localparam int EAW    = EYW - ENERGY_PRE_SHIFT;
  localparam int ED     = (EAW + 7) / 8;         // byte stages of the divide by 125
  localparam int EQW    = ED * 8;
  localparam int ESW    = (EQW > ENERGY_BITS) ? EQW + 1 : ENERGY_BITS + 1;
  localparam int ERW    = 7;                     // remainder of a divide by 125
  localparam int ETW    = ERW + 8;               // remainder and next byte
  localparam int EPW    = ETW + 16;              // reciprocal product width
  localparam int DLE    = ED + 2;                // energy divider latency
  localparam int LAT    = 3 + DL + ENERGY_LAT + 1 + DLE;
  localparam logic [ESW-1:0] E_POS_LIM = ESW'({1'b0, {(ENERGY_BITS-1){1'b1}}});
  localparam logic [ESW-1:0] E_NEG_LIM = ESW'({1'b1, {(ENERGY_BITS-1){1'b0}}});

  logic en;

  // efficiency register
  logic [EFF_BITS-1:0] eff_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_r <= EFF_RESET;
    end else if (cfg_wr_en) begin
      eff_r <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless the output holds a stalled transaction
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // unpack
  logic        [M-1:0] m1, m2;
  logic signed [V-1:0] a1 [2];
  logic signed [V-1:0] a2 [2];
  assign m1    = in_tdata[M-1:0];
  assign m2    = in_tdata[2*M-1:M];
  assign a1[0] = $signed(in_tdata[2*M+V-1:2*M]);
  assign a1[1] = $signed(in_tdata[2*M+2*V-1:2*M+V]);
  assign a2[0] = $signed(in_tdata[2*M+3*V-1:2*M+2*V]);
  assign a2[1] = $signed(in_tdata[2*M+4*V-1:2*M+3*V]);

  // stage 1: products
  logic signed [M:0]   dm;
  logic signed [M+1:0] m1x2, m2x2;
  logic signed [PW-1:0] x1 [2];
  logic signed [PW-1:0] y1 [2];
  logic signed [PW-1:0] x2 [2];
  logic signed [PW-1:0] y2 [2];
  assign dm   = $signed({1'b0, m1}) - $signed({1'b0, m2});
  assign m1x2 = $signed({1'b0, m1, 1'b0});
  assign m2x2 = $signed({1'b0, m2, 1'b0});
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      x1[c] = a1[c] * dm;
      y1[c] = a2[c] * m2x2;
      x2[c] = a2[c] * dm;
      y2[c] = a1[c] * m1x2;
    end
  end

  logic signed [PW-1:0] x1_r [2];
  logic signed [PW-1:0] y1_r [2];
  logic signed [PW-1:0] x2_r [2];
  logic signed [PW-1:0] y2_r [2];
  logic                mode_r1, zero_r1;
  logic [EFF_BITS-1:0] eff_r1;
  logic [M:0]          msum_r1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        x1_r[c] <= x1[c];
        y1_r[c] <= y1[c];
        x2_r[c] <= x2[c];
        y2_r[c] <= y2[c];
      end
      mode_r1 <= in_tuser;
      zero_r1 <= (m1 == '0) && (m2 == '0);
      eff_r1  <= eff_r;
      msum_r1 <= {1'b0, m1} + {1'b0, m2};
    end
  end

  // stage 2: elastic terms or inelastic momentum (products are even: halve exactly)
  logic signed [TW-1:0] t1_r [2];
  logic signed [TW-1:0] t2_r [2];
  logic                mode_r2, zero_r2;
  logic [EFF_BITS-1:0] eff_r2;
  logic [M:0]          msum_r2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        if (mode_r1) begin
          t1_r[c] <= (TW'(y1_r[c]) + TW'(y2_r[c])) >>> 1;
          t2_r[c] <= (TW'(y1_r[c]) + TW'(y2_r[c])) >>> 1;
        end else begin
          t1_r[c] <= TW'(x1_r[c]) + TW'(y1_r[c]);
          t2_r[c] <= TW'(y2_r[c]) - TW'(x2_r[c]);
        end
      end
      mode_r2 <= mode_r1;
      zero_r2 <= zero_r1;
      eff_r2  <= eff_r1;
      msum_r2 <= msum_r1;
    end
  end

  // stage 3: scale by efficiency, pick divisor
  logic signed [EFF_BITS:0] eff_s;
  logic signed [NW-1:0] num_r [4];
  logic [DW-1:0]        den_r3;
  logic                 zero_r3;
  assign eff_s = $signed({1'b0, eff_r2});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 2; c++) begin
        if (mode_r2) begin
          num_r[c]   <= NW'(t1_r[c]);
          num_r[c+2] <= NW'(t2_r[c]);
        end else begin
          num_r[c]   <= NW'(t1_r[c]) * NW'(eff_s);
          num_r[c+2] <= NW'(t2_r[c]) * NW'(eff_s);
        end
      end
      den_r3  <= mode_r2 ? DW'(msum_r2) : {msum_r2, {EFF_FRAC{1'b0}}};
      zero_r3 <= zero_r2;
    end
  end

  // velocity dividers: lanes first x, first y, second x, second y
  logic signed [V-1:0] vel_q [4];
  logic signed [V-1:0] vel_m [4];
  logic                zero_d;

  for (genvar g = 0; g < 4; g++) begin : g_vdiv
    bcr_div #(.NW(NW), .DW(DW), .OW(V)) u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[g]),
      .den (den_r3),
      .quo (vel_q[g])
    );
  end

  bcr_delay #(.W(1), .N(DL)) u_zero_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .din (zero_r3), .dout (zero_d)
  );

  // drop to zero when both masses are zero
  always_comb begin
    for (int i = 0; i < 4; i++) vel_m[i] = zero_d ? '0 : vel_q[i];
  end

  // energy before: straight from the input
  logic [EW-1:0] e0, e0_d, e1;
  bcr_energy #(.VW(V), .MW(M)) u_e0 (
    .clk (clk), .en (en), .m1 (m1), .m2 (m2),
    .v1x (a1[0]), .v1y (a1[1]), .v2x (a2[0]), .v2y (a2[1]),
    .energy (e0)
  );
  bcr_delay #(.W(EW), .N(DL+3)) u_e0_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .din (e0), .dout (e0_d)
  );

  // energy after: masses held until the new velocities are out
  logic [2*M-1:0] m_d;
  bcr_delay #(.W(2*M), .N(3+DL)) u_m_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .din ({m2, m1}), .dout (m_d)
  );
  bcr_energy #(.VW(V), .MW(M)) u_e1 (
    .clk (clk), .en (en), .m1 (m_d[M-1:0]), .m2 (m_d[2*M-1:M]),
    .v1x (vel_m[0]), .v1y (vel_m[1]), .v2x (vel_m[2]), .v2y (vel_m[3]),
    .energy (e1)
  );

  logic signed [EW:0] diff_r;
  always_ff @(posedge clk) begin
    if (en) diff_r <= $signed({1'b0, e0_d}) - $signed({1'b0, e1});
  end

  // sums of m*raw^2 over 2000 give energy/1000 in Q.16; round half away
  // from zero by adding 1000 to the magnitude, then floor-divide by 2000
  logic [EW:0]          emag, ey;
  logic [EQW-1:0]       ea_r     [ED+1];
  logic [EQW-1:0]       eq_r     [ED+1];
  logic [ERW-1:0]       erem_r   [ED+1];
  logic                 eneg_r   [ED+1];
  logic [EQW-1:0]       ea_nxt   [ED+1];
  logic [EQW-1:0]       eq_nxt   [ED+1];
  logic [ERW-1:0]       erem_nxt [ED+1];
  logic [ESW-1:0]       eqw, eqneg;
  logic [ENERGY_BITS-1:0]        esat;
  logic signed [ENERGY_BITS-1:0] energy_q;

  assign emag = diff_r[EW] ? EYW'(-diff_r) : EYW'(diff_r);
  assign ey   = emag + EYW'(ENERGY_HALF);

  // one quotient byte per stage: reciprocal multiply, then remainder
  always_comb begin
    logic [ETW-1:0] et;
    logic [EPW-1:0] eprod;
    logic [7:0]     edig;
    et    = '0;
    eprod = '0;
    edig  = '0;
    ea_nxt[0]   = '0;
    eq_nxt[0]   = '0;
    erem_nxt[0] = '0;
    for (int k = 1; k <= ED; k++) begin
      et          = {erem_r[k-1], ea_r[k-1][EQW-1 -: 8]};
      eprod       = EPW'(et) * EPW'(ENERGY_RECIP);
      edig        = eprod[ENERGY_RECIP_SHIFT +: 8];
      erem_nxt[k] = ERW'(et - ETW'(edig) * ETW'(ENERGY_ODD));
      ea_nxt[k]   = {ea_r[k-1][EQW-9:0], 8'h00};
      eq_nxt[k]   = {eq_r[k-1][EQW-9:0], edig};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r[0]   <= EQW'(ey[EW:ENERGY_PRE_SHIFT]);
      eq_r[0]   <= '0;
      erem_r[0] <= '0;
      eneg_r[0] <= diff_r[EW];
      for (int k = 1; k <= ED; k++) begin
        ea_r[k]   <= ea_nxt[k];
        eq_r[k]   <= eq_nxt[k];
        erem_r[k] <= erem_nxt[k];
        eneg_r[k] <= eneg_r[k-1];
      end
    end
  end

  // restore the sign and clamp to the energy range
  assign eqw   = ESW'(eq_r[ED]);
  assign eqneg = -eqw;

  always_comb begin
    if (eneg_r[ED] ? (eqw > E_NEG_LIM) : (eqw > E_POS_LIM)) begin
      esat = eneg_r[ED] ? {1'b1, {(ENERGY_BITS-1){1'b0}}}
                        : {1'b0, {(ENERGY_BITS-1){1'b1}}};
    end else begin
      esat = eneg_r[ED] ? eqneg[ENERGY_BITS-1:0] : eqw[ENERGY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) energy_q <= $signed(esat);
  end

  // hold velocities alongside the energy path
  logic [4*V-1:0] vel_out;
  bcr_delay #(.W(4*V), .N(ENERGY_LAT+1+DLE)) u_v_dly (
    .clk (clk), .rst_n (rst_n), .en (en),
    .din ({vel_m[3], vel_m[2], vel_m[1], vel_m[0]}), .dout (vel_out)
  );

  // valid bits travel with the data
  bcr_delay #(.W(1), .N(LAT)) u_vld_dly (
    .clk (clk), .rst_n (rst_n), .en (en), .din (in_tvalid), .dout (out_tvalid)
  );

  assign out_tdata = OUT_W'({energy_q, vel_out});
endmodule
`default_nettype wire
